### design/fvpc_pkg.sv
// shared constants and types for the partition chooser
package fvpc_pkg;
    localparam int NumParts = 16;
    localparam int PartW = 4;
    localparam int VertW = 16;
    localparam int NumVert = 65536;
    localparam int CntW = 17;
    localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
    localparam int SqrtW = 17;
    localparam int ScoreW = 50;
    localparam logic [1:0] CfgAlpha = 2'd0;
    localparam logic [1:0] CfgLimit = 2'd1;
    localparam logic [1:0] CfgActive = 2'd2;

    typedef struct packed {
        logic go;
        logic [CntW-1:0] size;
    } sqrt_req_t;

    typedef struct packed {
        logic done;
        logic [SqrtW-1:0] root;
    } sqrt_rsp_t;
endpackage

### design/fennel_vertex_partition_chooser_unit.sv
// top level of the fennel vertex partition chooser
//
//  channel  signals                                            direction
//  cmd      start busy req_type vertex_id neighbor_id
//           seed_part last_neighbor                            in (busy out)
//  result   done placed_vertex chosen_part                     out
//  config   cfg_we cfg_index cfg_data                          in
//
// after reset every word of the membership store is cleared, busy high
// a neighbor item does one store read on the single ram port
// a last neighbor then runs the shared sqrt and multiply once per active
// partition, then the store write; a seed item does the store read and write
// done pulses one cycle; the receiver cannot stall
module fennel_vertex_partition_chooser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [15:0] vertex_id,
    input  logic [15:0] neighbor_id,
    input  logic [3:0]  seed_part,
    input  logic        last_neighbor,
    output logic        done,
    output logic [15:0] placed_vertex,
    output logic [3:0]  chosen_part,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import fvpc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_NREAD, S_NCOUNT, S_SQGO, S_SQWAIT, S_MUL,
        S_CMP, S_PREAD, S_PWRITE
    } state_t;

    state_t state_reg;
    logic [31:0] alpha_reg;
    logic [CntW-1:0] limit_reg;
    logic [4:0] active_reg;
    logic [CntW-1:0] sizes_reg [NumParts];
    logic [CntW-1:0] counts_reg [NumParts];
    logic [VertW:0] clr_reg;
    logic [VertW-1:0] vid_reg, addr;
    logic [PartW-1:0] part_reg, best_reg;
    logic [4:0] act_eff;
    logic [PartW:0] p_reg;
    logic signed [ScoreW-1:0] best_score_reg, score;
    logic [48:0] prod_reg;
    logic [SqrtW-1:0] root_reg;
    logic done_reg;
    logic ram_we;
    logic [NumParts-1:0] wdata, rdata;
    sqrt_req_t sq_req;
    sqrt_rsp_t sq_rsp;
    logic [PartW-1:0] pi;
    logic [VertW-1:0] vert_hold;
    logic last_hold;

    assign pi = p_reg[PartW-1:0];
    assign act_eff = (active_reg == 5'd0) ? 5'd1 :
                     (active_reg > 5'(NumParts)) ? 5'(NumParts) : active_reg;

    always_comb
    begin
        addr = vid_reg;
        ram_we = 1'b0;
        wdata = rdata | (NumParts'(1) << part_reg);
        if (state_reg == S_CLEAR)
        begin
            addr = clr_reg[VertW-1:0];
            ram_we = 1'b1;
            wdata = '0;
        end
        else if (state_reg == S_PWRITE)
        begin
            ram_we = 1'b1;
        end
    end

    fvpc_ram #(.Width(NumParts), .Depth(NumVert)) u_mem (
        .clk(clk), .we(ram_we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign sq_req.go = (state_reg == S_SQGO);
    assign sq_req.size = sizes_reg[pi];

    fvpc_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));

    always_comb
    begin
        if (sizes_reg[pi] <= limit_reg)
        begin
            score = $signed({1'b0, counts_reg[pi], 16'd0})
                  - $signed({1'b0, prod_reg[48:8]});
        end
        else
        begin
            score = '0;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign placed_vertex = vid_reg;
    assign chosen_part = part_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            done_reg <= 1'b0;
            alpha_reg <= 32'd65536;
            limit_reg <= CntW'(65536);
            active_reg <= 5'd16;
            for (int i = 0; i < NumParts; i++)
            begin
                sizes_reg[i] <= '0;
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= (state_reg == S_PWRITE);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CfgAlpha:  alpha_reg <= cfg_data;
                    CfgLimit:  limit_reg <= cfg_data[CntW-1:0];
                    CfgActive: active_reg <= cfg_data[4:0];
                    default:   ;
                endcase
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (VertW+1)'(NumVert - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (req_type)
                        begin
                            vid_reg <= vertex_id;
                            part_reg <= seed_part;
                            state_reg <= S_PREAD;
                        end
                        else
                        begin
                            vid_reg <= neighbor_id;
                            part_reg <= '0;
                            state_reg <= S_NREAD;
                        end
                    end
                end
                S_NREAD:
                begin
                    state_reg <= S_NCOUNT;
                end
                S_NCOUNT:
                begin
                    for (int i = 0; i < NumParts; i++)
                    begin
                        if (rdata[i] && counts_reg[i] != CntMax)
                        begin
                            counts_reg[i] <= counts_reg[i] + 1'b1;
                        end
                    end
                    if (last_hold)
                    begin
                        vid_reg <= vert_hold;
                        p_reg <= '0;
                        state_reg <= S_SQGO;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SQGO:
                begin
                    state_reg <= S_SQWAIT;
                end
                S_SQWAIT:
                begin
                    if (sq_rsp.done)
                    begin
                        root_reg <= sq_rsp.root;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg <= alpha_reg * root_reg;
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (p_reg == '0 || score > best_score_reg)
                    begin
                        best_score_reg <= score;
                        best_reg <= pi;
                    end
                    if (p_reg + 1'b1 == act_eff)
                    begin
                        part_reg <= (p_reg == '0 || score > best_score_reg) ? pi : best_reg;
                        for (int i = 0; i < NumParts; i++)
                        begin
                            counts_reg[i] <= '0;
                        end
                        state_reg <= S_PREAD;
                    end
                    else
                    begin
                        p_reg <= p_reg + 1'b1;
                        state_reg <= S_SQGO;
                    end
                end
                S_PREAD:
                begin
                    state_reg <= S_PWRITE;
                end
                S_PWRITE:
                begin
                    if (!rdata[part_reg] && sizes_reg[part_reg] != CntMax)
                    begin
                        sizes_reg[part_reg] <= sizes_reg[part_reg] + 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start && !req_type)
        begin
            vert_hold <= vertex_id;
            last_hold <= last_neighbor;
        end
    end

`ifndef SYNTHESIS
    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_PWRITE))
        else $error("result without placement write");
    a_busy_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");
    a_part_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (p_reg < act_eff))
        else $error("scan beyond active partitions");
`endif
endmodule

### design/fvpc_ram.sv
// generic single port ram with registered read
module fvpc_ram #(
    parameter int Width = 16,
    parameter int Depth = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### design/fvpc_sqrt.sv
// iterative integer square root, one result bit per cycle
module fvpc_sqrt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fvpc_pkg::sqrt_req_t   req,
    output fvpc_pkg::sqrt_rsp_t   rsp
);
    import fvpc_pkg::*;

    localparam int XW = CntW + 16;
    localparam int RemW = 2 * SqrtW;
    localparam int StepW = $clog2(SqrtW + 1);

    logic [RemW-1:0] rem_reg, rem_next;
    logic [SqrtW-1:0] root_reg, root_next;
    logic [StepW-1:0] step_reg, step_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [XW+1:0] trial;
    logic [XW+1:0] rem_sh;
    logic [XW+1:0] acc_reg, acc_next;

    always_comb
    begin
        rem_next = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        acc_next = acc_reg;
        done_next = 1'b0;
        rem_sh = {acc_reg[XW-1:0], rem_reg[RemW-1 -: 2]};
        trial = (XW+2)'({root_reg, 2'b01});
        if (req.go)
        begin
            rem_next = {1'b0, req.size, 16'd0};
            acc_next = '0;
            root_next = '0;
            step_next = StepW'(SqrtW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = {rem_reg[RemW-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                acc_next = rem_sh - trial;
                root_next = {root_reg[SqrtW-2:0], 1'b1};
            end
            else
            begin
                acc_next = rem_sh;
                root_next = {root_reg[SqrtW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == StepW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        root_reg <= root_next;
        acc_reg <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;
endmodule
